@@ rtl/limit_order_book_matcher_unit_macros.svh @@
// Assertion macros used by the checker file.
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define LOBM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lobm check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define LOBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lobm check failed");

`endif

@@ rtl/lobm_pkg.sv @@
// ----------------------------------------------------------------------------
// lobm_pkg
// Types and constants of the order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int SIDE_DEPTH  = 32;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_MATCH = 1'b1;

    localparam logic [1:0] KIND_TRADE    = 2'd0;
    localparam logic [1:0] KIND_NO_CROSS = 2'd1;
    localparam logic [1:0] KIND_REJECT   = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [31:0] price;
        logic [31:0] qty;
        logic [31:0] id;
    } entry_t;

    typedef struct packed {
        logic        ins;
        logic        rem;
        logic        upd;
        logic [31:0] qty;
    } side_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_MATCH
    } state_t;

endpackage

@@ rtl/lobm_cell.sv @@
// ----------------------------------------------------------------------------
// lobm_cell
// One slot of a sorted side: keeps, takes the new order, shifts, or has its quantity updated.
// ----------------------------------------------------------------------------
module lobm_cell
    import lobm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       is_bid,
    input  side_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  entry_t     prev_entry,
    input  entry_t     next_entry,
    input  logic       prev_ahead,
    output entry_t     entry,
    output logic       ahead
);

    entry_t entry_reg;
    entry_t entry_next;

    // Slot stays in front of the incoming order (FIFO within a price).
    assign ahead = entry_reg.valid &&
                   (is_bid ? (entry_reg.price >= new_entry.price)
                           : (entry_reg.price <= new_entry.price));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (!ahead)
                entry_next = prev_ahead ? new_entry : prev_entry;
        end
        else if (ctrl.rem)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.upd)
        begin
            entry_next.qty = ctrl.qty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ rtl/lobm_side.sv @@
// ----------------------------------------------------------------------------
// lobm_side
// Row of cells holding one side of the book, best order in cell zero.
// ----------------------------------------------------------------------------
module lobm_side
    import lobm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       is_bid,
    input  side_ctrl_t ctrl,
    input  entry_t     new_entry,
    output entry_t     front,
    output entry_t     second,
    output logic       full
);

    entry_t cells  [SIDE_DEPTH];
    logic   aheads [SIDE_DEPTH];

    genvar i;
    generate
        for (i = 0; i < SIDE_DEPTH; i++)
        begin : g_cell
            side_ctrl_t cell_ctrl;
            entry_t     prev_e;
            entry_t     next_e;
            logic       prev_a;

            // Only the front cell is reduced in place.
            always_comb
            begin
                cell_ctrl     = ctrl;
                cell_ctrl.upd = ctrl.upd && (i == 0);
            end

            if (i == 0)
            begin : g_first
                assign prev_e = new_entry;
                assign prev_a = 1'b1;
            end
            else
            begin : g_mid
                assign prev_e = cells[i-1];
                assign prev_a = aheads[i-1];
            end

            if (i == SIDE_DEPTH - 1)
            begin : g_last
                assign next_e = '0;
            end
            else
            begin : g_inner
                assign next_e = cells[i+1];
            end

            lobm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .is_bid     (is_bid),
                .ctrl       (cell_ctrl),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .prev_ahead (prev_a),
                .entry      (cells[i]),
                .ahead      (aheads[i])
            );
        end
    endgenerate

    assign front  = cells[0];
    assign second = cells[1];
    assign full   = cells[SIDE_DEPTH-1].valid;

endmodule

@@ rtl/limit_order_book_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Price-time priority limit order book with a crossing engine.
// ----------------------------------------------------------------------------
// Each side is a row of SIDE_DEPTH cells kept sorted best first; an add is
// placed by all cells comparing against it and shifting in parallel; an add to
// a full side is not placed and gives a reject result instead. A match
// transaction crosses the front cells once per cycle, giving one trade per
// cycle while the output is taken, up to MAX_RESULTS trades, and the block
// accepts no new transaction until the last result of the match is out.
module limit_order_book_matcher_unit
    import lobm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,  // price[31:0], quantity[63:32], id[95:64]
    input  logic [1:0]  s_tuser,  // opcode[0], side[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // buyer_id[31:0], seller_id[63:32], traded_amount[95:64]
    output logic [1:0]  m_tuser,  // kind[1:0]
    output logic        m_tlast
);

    state_t            state_reg,   state_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [95:0]       m_data_reg,  m_data_next;
    logic [1:0]        m_user_reg,  m_user_next;
    logic              m_last_reg,  m_last_next;

    side_ctrl_t bid_ctrl, ask_ctrl;
    entry_t     new_entry;
    entry_t     bid_front, bid_second, ask_front, ask_second;
    entry_t     bid_nf, ask_nf;
    logic       bid_full, ask_full;
    logic       out_free, has_cross, cross_after;
    logic [31:0] amount;

    assign new_entry = '{valid: 1'b1, price: s_tdata[31:0], qty: s_tdata[63:32],
                         id: s_tdata[95:64]};

    lobm_side u_bid (
        .clk       (clk),
        .rst_n     (rst_n),
        .is_bid    (1'b1),
        .ctrl      (bid_ctrl),
        .new_entry (new_entry),
        .front     (bid_front),
        .second    (bid_second),
        .full      (bid_full)
    );

    lobm_side u_ask (
        .clk       (clk),
        .rst_n     (rst_n),
        .is_bid    (1'b0),
        .ctrl      (ask_ctrl),
        .new_entry (new_entry),
        .front     (ask_front),
        .second    (ask_second),
        .full      (ask_full)
    );

    assign out_free  = !m_valid_reg || m_tready;
    assign has_cross = (cnt_reg < CNT_W'(MAX_RESULTS)) && bid_front.valid &&
                       ask_front.valid && (bid_front.price >= ask_front.price);
    assign amount    = (bid_front.qty < ask_front.qty) ? bid_front.qty : ask_front.qty;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        bid_ctrl     = '0;
        ask_ctrl     = '0;
        s_tready     = 1'b0;
        bid_nf       = bid_front;
        ask_nf       = ask_front;
        cross_after  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = out_free;
                if (s_tvalid && out_free)
                begin
                    if (s_tuser[0] == OP_ADD)
                    begin
                        if (s_tuser[1] ? ask_full : bid_full)
                        begin
                            m_valid_next = 1'b1;
                            m_data_next  = {64'd0, s_tdata[95:64]};
                            m_user_next  = KIND_REJECT;
                            m_last_next  = 1'b1;
                        end
                        else if (s_tuser[1])
                            ask_ctrl.ins = 1'b1;
                        else
                            bid_ctrl.ins = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_MATCH;
                        cnt_next   = '0;
                    end
                end
            end
            ST_MATCH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    if (!has_cross)
                    begin
                        m_data_next = '0;
                        m_user_next = KIND_NO_CROSS;
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        if (bid_front.qty > ask_front.qty)
                        begin
                            bid_ctrl.upd = 1'b1;
                            bid_ctrl.qty = bid_front.qty - ask_front.qty;
                            ask_ctrl.rem = 1'b1;
                        end
                        else if (bid_front.qty < ask_front.qty)
                        begin
                            ask_ctrl.upd = 1'b1;
                            ask_ctrl.qty = ask_front.qty - bid_front.qty;
                            bid_ctrl.rem = 1'b1;
                        end
                        else
                        begin
                            bid_ctrl.rem = 1'b1;
                            ask_ctrl.rem = 1'b1;
                        end
                        // Look ahead at the fronts left behind to mark the last trade.
                        bid_nf      = bid_ctrl.rem ? bid_second : bid_front;
                        ask_nf      = ask_ctrl.rem ? ask_second : ask_front;
                        cross_after = (cnt_reg + CNT_W'(1) < CNT_W'(MAX_RESULTS)) &&
                                      bid_nf.valid && ask_nf.valid &&
                                      (bid_nf.price >= ask_nf.price);
                        m_data_next = {amount, ask_front.id, bid_front.id};
                        m_user_next = KIND_TRADE;
                        m_last_next = !cross_after;
                        cnt_next    = cnt_reg + CNT_W'(1);
                        if (!cross_after)
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ rtl/lobm_checker.sv @@
// ----------------------------------------------------------------------------
// lobm_checker
// Port-level checks of the order book matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "limit_order_book_matcher_unit_macros.svh"

module lobm_checker
    import lobm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    `LOBM_ASSERT_NOW(a_kind_legal, m_tvalid, m_tuser <= KIND_REJECT)
    `LOBM_ASSERT_NOW(a_no_cross_empty, m_tvalid && (m_tuser == KIND_NO_CROSS),
        (m_tdata == 96'd0) && m_tlast)
    `LOBM_ASSERT_NOW(a_reject_single, m_tvalid && (m_tuser == KIND_REJECT),
        (m_tdata[95:32] == 64'd0) && m_tlast)
    `LOBM_ASSERT_NOW(a_no_overrun, s_tready && m_tvalid, m_tready)
    `LOBM_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind limit_order_book_matcher_unit lobm_checker u_lobm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
